// ----- hdl/blpf_pkg.sv -----
package blpf_pkg;

    localparam int DEF_MAX_WIDTH  = 128;
    localparam int DEF_MAX_HEIGHT = 64;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_DISPLAY_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DISPLAY_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_STROKE_ENABLE  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_STROKE_COLOUR  = 2'd3;

    localparam logic [7:0] RST_DISPLAY_WIDTH  = 8'd128;
    localparam logic [6:0] RST_DISPLAY_HEIGHT = 7'd64;
    localparam logic       RST_STROKE_ENABLE  = 1'b1;
    localparam logic       RST_STROKE_COLOUR  = 1'b1;

    localparam logic [1:0] OP_DRAW  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam int COORD_W = 12;
    localparam int ADDR_W  = 10;
    localparam int ERR_W   = 16;

    localparam logic [7:0] BLANK_BYTE = 8'h00;

    typedef struct packed {
        logic load;
        logic setup;
        logic pix_read;
        logic pix_write;
        logic step;
        logic clr_write;
        logic rd_issue;
        logic rd_capture;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic stroke_en;
        logic line_done;
        logic clr_last;
    } dp_status_t;

endpackage

// ----- hdl/bresenham_line_to_page_framebuffer_core.sv -----
// Line engine over a page-organised one-bit-per-pixel framebuffer held in a
// byte memory with one write port and one read port. After reset the block
// sweeps the memory clear, one byte per cycle, and accepts no item until that
// is done. A draw sets up the line and then, for each of its max(|dx|,|dy|)+1
// points, reads the pixel's byte and writes it back with the bit set or
// cleared; off-screen points are stepped over through the same read and write
// steps with the write suppressed. A read issues the address and captures the
// byte, a clear sweeps the whole memory byte by byte, and a draw with the
// stroke off or an unused operation goes straight to the result. The next item
// is taken while a result waits in the output register.
module bresenham_line_to_page_framebuffer_core #(
    parameter int MAX_WIDTH  = blpf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = blpf_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_write_enable,
    input  logic [blpf_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [blpf_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_operation,
    input  logic signed [blpf_pkg::COORD_W-1:0] s_start_x,
    input  logic signed [blpf_pkg::COORD_W-1:0] s_start_y,
    input  logic signed [blpf_pkg::COORD_W-1:0] s_end_x,
    input  logic signed [blpf_pkg::COORD_W-1:0] s_end_y,
    input  logic [blpf_pkg::ADDR_W-1:0]         s_read_address,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [7:0]                          m_read_data,
    output logic                                m_address_error
);

    blpf_pkg::ctrl_cmd_t  cmd;
    blpf_pkg::dp_status_t status;

    blpf_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .status      (status),
        .cmd         (cmd)
    );

    blpf_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_start_x        (s_start_x),
        .s_start_y        (s_start_y),
        .s_end_x          (s_end_x),
        .s_end_y          (s_end_y),
        .s_read_address   (s_read_address),
        .cmd              (cmd),
        .status           (status),
        .m_read_data      (m_read_data),
        .m_address_error  (m_address_error)
    );

endmodule

// ----- hdl/blpf_datapath.sv -----
module blpf_datapath #(
    parameter int MAX_WIDTH  = blpf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = blpf_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_write_enable,
    input  logic [blpf_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [blpf_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic signed [blpf_pkg::COORD_W-1:0]    s_start_x,
    input  logic signed [blpf_pkg::COORD_W-1:0]    s_start_y,
    input  logic signed [blpf_pkg::COORD_W-1:0]    s_end_x,
    input  logic signed [blpf_pkg::COORD_W-1:0]    s_end_y,
    input  logic [blpf_pkg::ADDR_W-1:0]            s_read_address,
    input  blpf_pkg::ctrl_cmd_t                    cmd,
    output blpf_pkg::dp_status_t                   status,
    output logic [7:0]                             m_read_data,
    output logic                                   m_address_error
);

    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT / 8;
    localparam int AW  = $clog2(STORE_DEPTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int PGW = $clog2(MAX_HEIGHT / 8 + 1);
    localparam int SW  = $clog2(STORE_DEPTH + 1);
    localparam int CW  = blpf_pkg::COORD_W;
    localparam int EW  = blpf_pkg::ERR_W;

    logic [7:0] cfg_width_reg;
    logic [6:0] cfg_height_reg;
    logic       cfg_stroke_en_reg;
    logic       cfg_colour_reg;

    logic signed [CW-1:0] x_reg, y_reg, x1_reg, y1_reg;
    logic [blpf_pkg::ADDR_W-1:0] raddr_reg;
    logic [CW-1:0] dx_reg, dy_reg;
    logic sxn_reg, syn_reg, xmaj_reg;
    logic signed [EW-1:0] err_reg;
    logic [AW-1:0] pix_addr_reg;
    logic pix_ok_reg;
    logic [2:0] pix_bit_reg;
    logic [AW-1:0] clr_addr_reg;
    logic [7:0] res_data_reg;
    logic res_err_reg;
    logic [7:0] m_data_reg;
    logic m_err_reg;

    logic [7:0] mem [STORE_DEPTH];
    logic [7:0] mem_q;

    logic [WW-1:0]  act_width;
    logic [7:0]     height_sat;
    logic [PGW-1:0] act_pages;
    logic [SW-1:0]  act_size;

    always_comb begin
        if (cfg_width_reg == 8'd0) begin
            act_width = WW'(1);
        end else if (32'(cfg_width_reg) > MAX_WIDTH) begin
            act_width = WW'(MAX_WIDTH);
        end else begin
            act_width = WW'(cfg_width_reg);
        end
        if (cfg_height_reg < 7'd8) begin
            height_sat = 8'd8;
        end else if (32'(cfg_height_reg) > MAX_HEIGHT) begin
            height_sat = 8'(MAX_HEIGHT);
        end else begin
            height_sat = {1'b0, cfg_height_reg};
        end
        act_pages = PGW'(height_sat[7:3]);
        act_size  = SW'(act_width) * SW'(act_pages);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_width_reg     <= blpf_pkg::RST_DISPLAY_WIDTH;
            cfg_height_reg    <= blpf_pkg::RST_DISPLAY_HEIGHT;
            cfg_stroke_en_reg <= blpf_pkg::RST_STROKE_ENABLE;
            cfg_colour_reg    <= blpf_pkg::RST_STROKE_COLOUR;
        end else if (cfg_write_enable) begin
            case (cfg_index)
                blpf_pkg::CFG_DISPLAY_WIDTH:  cfg_width_reg     <= cfg_data;
                blpf_pkg::CFG_DISPLAY_HEIGHT: cfg_height_reg    <= cfg_data[6:0];
                blpf_pkg::CFG_STROKE_ENABLE:  cfg_stroke_en_reg <= cfg_data[0];
                blpf_pkg::CFG_STROKE_COLOUR:  cfg_colour_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    logic signed [CW:0] diff_x, diff_y;
    logic [CW-1:0] abs_x, abs_y;
    logic init_xmaj;
    logic signed [EW-1:0] init_err;

    always_comb begin
        diff_x = {x1_reg[CW-1], x1_reg} - {x_reg[CW-1], x_reg};
        diff_y = {y1_reg[CW-1], y1_reg} - {y_reg[CW-1], y_reg};
        abs_x  = diff_x[CW] ? CW'(-diff_x) : diff_x[CW-1:0];
        abs_y  = diff_y[CW] ? CW'(-diff_y) : diff_y[CW-1:0];
        init_xmaj = abs_x >= abs_y;
        if (init_xmaj) begin
            init_err = $signed(EW'({abs_y, 1'b0}) - EW'(abs_x));
        end else begin
            init_err = $signed(EW'({abs_x, 1'b0}) - EW'(abs_y));
        end
    end

    logic err_pos;
    logic [EW-1:0] minor_sub, major_add;
    logic signed [EW-1:0] err_next;
    logic x_move, y_move;

    always_comb begin
        err_pos   = err_reg > $signed(EW'(0));
        minor_sub = xmaj_reg ? EW'({dx_reg, 1'b0}) : EW'({dy_reg, 1'b0});
        major_add = xmaj_reg ? EW'({dy_reg, 1'b0}) : EW'({dx_reg, 1'b0});
        err_next  = $signed(EW'(err_reg) + major_add - (err_pos ? minor_sub : EW'(0)));
        x_move    = xmaj_reg || err_pos;
        y_move    = !xmaj_reg || err_pos;
    end

    logic pix_ok;
    logic [AW-1:0] pix_idx;

    always_comb begin
        pix_ok = !x_reg[CW-1] && !y_reg[CW-1]
              && ({1'b0, x_reg[CW-2:0]} < CW'(act_width))
              && (y_reg[CW-2:3] < (CW-4)'(act_pages));
        pix_idx = AW'(y_reg[CW-2:3]) * AW'(act_width) + AW'(x_reg[CW-2:0]);
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x_reg     <= s_start_x;
            y_reg     <= s_start_y;
            x1_reg    <= s_end_x;
            y1_reg    <= s_end_y;
            raddr_reg <= s_read_address;
        end else if (cmd.step) begin
            if (x_move) begin
                x_reg <= sxn_reg ? x_reg - CW'(1) : x_reg + CW'(1);
            end
            if (y_move) begin
                y_reg <= syn_reg ? y_reg - CW'(1) : y_reg + CW'(1);
            end
        end
        if (cmd.setup) begin
            dx_reg   <= abs_x;
            dy_reg   <= abs_y;
            sxn_reg  <= diff_x[CW];
            syn_reg  <= diff_y[CW];
            xmaj_reg <= init_xmaj;
            err_reg  <= init_err;
        end else if (cmd.step) begin
            err_reg <= err_next;
        end
        if (cmd.pix_read) begin
            pix_addr_reg <= pix_idx;
            pix_ok_reg   <= pix_ok;
            pix_bit_reg  <= y_reg[2:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clr_write) begin
            if (32'(clr_addr_reg) == STORE_DEPTH - 1) begin
                clr_addr_reg <= '0;
            end else begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
        end
    end

    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_wdata, pix_mask;

    always_comb begin
        pix_mask  = 8'(1) << pix_bit_reg;
        mem_we    = cmd.clr_write || (cmd.pix_write && pix_ok_reg);
        mem_waddr = cmd.clr_write ? clr_addr_reg : pix_addr_reg;
        if (cmd.clr_write) begin
            mem_wdata = blpf_pkg::BLANK_BYTE;
        end else if (cfg_colour_reg) begin
            mem_wdata = mem_q | pix_mask;
        end else begin
            mem_wdata = mem_q & ~pix_mask;
        end
        mem_raddr = cmd.rd_issue ? AW'(raddr_reg) : pix_idx;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_q <= mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            res_data_reg <= blpf_pkg::BLANK_BYTE;
            res_err_reg  <= 1'b0;
        end else if (cmd.rd_issue) begin
            res_err_reg <= 32'(raddr_reg) >= 32'(act_size);
        end else if (cmd.rd_capture) begin
            res_data_reg <= res_err_reg ? blpf_pkg::BLANK_BYTE : mem_q;
        end
        if (cmd.out_load) begin
            m_data_reg <= res_data_reg;
            m_err_reg  <= res_err_reg;
        end
    end

    assign status.stroke_en = cfg_stroke_en_reg;
    assign status.line_done = (x_reg == x1_reg) && (y_reg == y1_reg);
    assign status.clr_last  = 32'(clr_addr_reg) == STORE_DEPTH - 1;

    assign m_read_data     = m_data_reg;
    assign m_address_error = m_err_reg;

endmodule

// ----- hdl/blpf_ctrl.sv -----
module blpf_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_operation,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  blpf_pkg::dp_status_t status,
    output blpf_pkg::ctrl_cmd_t  cmd
);

    localparam logic [3:0] S_INIT    = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_SETUP   = 4'd2;
    localparam logic [3:0] S_PREAD   = 4'd3;
    localparam logic [3:0] S_PWRITE  = 4'd4;
    localparam logic [3:0] S_CLEAR   = 4'd5;
    localparam logic [3:0] S_RDISSUE = 4'd6;
    localparam logic [3:0] S_RDCAP   = 4'd7;
    localparam logic [3:0] S_RESP    = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = state_reg == S_IDLE;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_INIT: begin
                cmd.clr_write = 1'b1;
                if (status.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load = 1'b1;
                    case (s_operation)
                        blpf_pkg::OP_DRAW:  state_next = status.stroke_en ? S_SETUP : S_RESP;
                        blpf_pkg::OP_READ:  state_next = S_RDISSUE;
                        blpf_pkg::OP_CLEAR: state_next = S_CLEAR;
                        default:            state_next = S_RESP;
                    endcase
                end
            end
            S_SETUP: begin
                cmd.setup  = 1'b1;
                state_next = S_PREAD;
            end
            S_PREAD: begin
                cmd.pix_read = 1'b1;
                state_next   = S_PWRITE;
            end
            S_PWRITE: begin
                cmd.pix_write = 1'b1;
                if (status.line_done) begin
                    state_next = S_RESP;
                end else begin
                    cmd.step   = 1'b1;
                    state_next = S_PREAD;
                end
            end
            S_CLEAR: begin
                cmd.clr_write = 1'b1;
                if (status.clr_last) begin
                    state_next = S_RESP;
                end
            end
            S_RDISSUE: begin
                cmd.rd_issue = 1'b1;
                state_next   = S_RDCAP;
            end
            S_RDCAP: begin
                cmd.rd_capture = 1'b1;
                state_next     = S_RESP;
            end
            S_RESP: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

`ifndef SYNTHESIS
    a_load_into_free_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result loaded over a pending transfer");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg != S_IDLE))
        else $error("accepted item did not start work");

    a_write_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PWRITE) |-> ($past(state_reg) == S_PREAD))
        else $error("pixel write without preceding read");

    a_valid_from_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(cmd.out_load))
        else $error("result valid without a load");
`endif

endmodule

// ----- tb/bresenham_line_to_page_framebuffer_core_test.sv -----
`timescale 1ns / 100ps

module bresenham_line_to_page_framebuffer_core_test;

    localparam int MAX_W        = blpf_pkg::DEF_MAX_WIDTH;
    localparam int MAX_H        = blpf_pkg::DEF_MAX_HEIGHT;
    localparam int STORE_DEPTH  = MAX_W * MAX_H / 8;
    localparam int CYCLE_LIMIT  = 3000000;
    localparam int HOLD_CYCLES  = 3000;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 123;
    localparam int SETTLE       = 50;

    localparam logic [1:0] OP_SPARE = 2'd3;

    localparam logic signed [blpf_pkg::COORD_W-1:0] COORD_LO = 12'h800;
    localparam logic signed [blpf_pkg::COORD_W-1:0] COORD_HI = 12'h7FF;

    typedef struct packed {
        logic [1:0]                          op;
        logic signed [blpf_pkg::COORD_W-1:0] sx;
        logic signed [blpf_pkg::COORD_W-1:0] sy;
        logic signed [blpf_pkg::COORD_W-1:0] ex;
        logic signed [blpf_pkg::COORD_W-1:0] ey;
        logic [blpf_pkg::ADDR_W-1:0]         addr;
    } pix_req_t;

    typedef struct packed {
        logic [7:0] data;
        logic       err;
    } read_reply_t;

    typedef struct packed {
        pix_req_t    req;
        logic        typed;
        read_reply_t reply;
    } script_row_t;

    localparam read_reply_t ZERO_REPLY = '{blpf_pkg::BLANK_BYTE, 1'b0};

    localparam int DIRECTED_ROWS = 24;
    localparam script_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{'{blpf_pkg::OP_READ, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 10'd0}, 1'b1, ZERO_REPLY},
        '{'{blpf_pkg::OP_READ, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 10'd1023}, 1'b1, ZERO_REPLY},
        '{'{OP_SPARE, COORD_LO, COORD_HI, COORD_HI, COORD_LO, 10'd1023}, 1'b1,
          ZERO_REPLY},
        '{'{blpf_pkg::OP_DRAW, -12'sd5, 12'sd0, 12'sd200, 12'sd0, 10'd0}, 1'b0,
          ZERO_REPLY},
        '{'{blpf_pkg::OP_READ, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 10'd0}, 1'b0, ZERO_REPLY},
        '{'{blpf_pkg::OP_READ, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 10'd127}, 1'b0, ZERO_REPLY},
        '{'{blpf_pkg::OP_DRAW, 12'sd5, -12'sd3, 12'sd5, 12'sd70, 10'd0}, 1'b0,
          ZERO_REPLY},
        '{'{blpf_pkg::OP_READ, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 10'd5}, 1'b0, ZERO_REPLY},
        '{'{blpf_pkg::OP_READ, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 10'd901}, 1'b0, ZERO_REPLY},
        '{'{blpf_pkg::OP_DRAW, 12'sd10, 12'sd10, 12'sd60, 12'sd25, 10'd0}, 1'b0,
          ZERO_REPLY},
        '{'{blpf_pkg::OP_DRAW, 12'sd70, 12'sd60, 12'sd62, 12'sd2, 10'd0}, 1'b0,
          ZERO_REPLY},
        '{'{blpf_pkg::OP_READ, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 10'd138}, 1'b0, ZERO_REPLY},
        '{'{blpf_pkg::OP_DRAW, 12'sd127, 12'sd63, 12'sd127, 12'sd63, 10'd0}, 1'b0,
          ZERO_REPLY},
        '{'{blpf_pkg::OP_READ, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 10'd1023}, 1'b0, ZERO_REPLY},
        '{'{blpf_pkg::OP_DRAW, COORD_LO, COORD_LO, COORD_HI, COORD_HI, 10'd0}, 1'b0,
          ZERO_REPLY},
        '{'{blpf_pkg::OP_DRAW, COORD_HI, COORD_LO, COORD_LO, COORD_HI, 10'd0}, 1'b0,
          ZERO_REPLY},
        '{'{blpf_pkg::OP_READ, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 10'd136}, 1'b0, ZERO_REPLY},
        '{'{blpf_pkg::OP_DRAW, COORD_HI, 12'sd40, COORD_LO, 12'sd40, 10'd0}, 1'b0,
          ZERO_REPLY},
        '{'{blpf_pkg::OP_READ, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 10'd704}, 1'b0, ZERO_REPLY},
        '{'{blpf_pkg::OP_CLEAR, COORD_HI, COORD_HI, COORD_LO, COORD_LO, 10'd1023}, 1'b1,
          ZERO_REPLY},
        '{'{blpf_pkg::OP_READ, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 10'd136}, 1'b1, ZERO_REPLY},
        '{'{blpf_pkg::OP_READ, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 10'd1023}, 1'b1, ZERO_REPLY},
        '{'{blpf_pkg::OP_DRAW, 12'sd2000, 12'sd2000, COORD_HI, 12'sd1990, 10'd0}, 1'b0,
          ZERO_REPLY},
        '{'{blpf_pkg::OP_READ, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 10'd0}, 1'b1, ZERO_REPLY}
    };

    localparam logic [7:0] PHASE_WIDTH  [8] = '{8'd128, 8'd0, 8'd255, 8'd37,
                                                8'd128, 8'd1, 8'd200, 8'd90};
    localparam logic [7:0] PHASE_HEIGHT [8] = '{8'd64, 8'd0, 8'd127, 8'd21,
                                                8'd64, 8'd8, 8'd70, 8'd40};
    localparam logic       PHASE_ENABLE [8] = '{1'b1, 1'b1, 1'b1, 1'b1,
                                                1'b0, 1'b1, 1'b1, 1'b1};
    localparam logic       PHASE_COLOUR [8] = '{1'b1, 1'b1, 1'b0, 1'b1,
                                                1'b1, 1'b1, 1'b0, 1'b1};

    logic                                aclk             = 1'b0;
    logic                                aresetn          = 1'b0;
    logic                                cfg_write_enable = 1'b0;
    logic [blpf_pkg::CFG_INDEX_W-1:0]    cfg_index        = '0;
    logic [blpf_pkg::CFG_DATA_W-1:0]     cfg_data         = '0;
    logic                                s_valid          = 1'b0;
    logic                                s_ready;
    logic [1:0]                          s_operation      = blpf_pkg::OP_DRAW;
    logic signed [blpf_pkg::COORD_W-1:0] s_start_x        = '0;
    logic signed [blpf_pkg::COORD_W-1:0] s_start_y        = '0;
    logic signed [blpf_pkg::COORD_W-1:0] s_end_x          = '0;
    logic signed [blpf_pkg::COORD_W-1:0] s_end_y          = '0;
    logic [blpf_pkg::ADDR_W-1:0]         s_read_address   = '0;
    logic                                m_valid;
    logic                                m_ready          = 1'b0;
    logic [7:0]                          m_read_data;
    logic                                m_address_error;

    logic [7:0]  pixel_pages [STORE_DEPTH];
    logic [7:0]  model_width  = blpf_pkg::RST_DISPLAY_WIDTH;
    logic [6:0]  model_height = blpf_pkg::RST_DISPLAY_HEIGHT;
    logic        model_enable = blpf_pkg::RST_STROKE_ENABLE;
    logic        model_colour = blpf_pkg::RST_STROKE_COLOUR;

    read_reply_t replies_due [$];
    int          mismatches    = 0;
    int          results_seen  = 0;
    int unsigned cycle_count   = 0;
    bit          steady_source = 1'b0;

    bresenham_line_to_page_framebuffer_core #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_operation      (s_operation),
        .s_start_x        (s_start_x),
        .s_start_y        (s_start_y),
        .s_end_x          (s_end_x),
        .s_end_y          (s_end_y),
        .s_read_address   (s_read_address),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_read_data      (m_read_data),
        .m_address_error  (m_address_error)
    );

    always #5 aclk = ~aclk;

    function automatic int used_width();
        int w;
        w = int'(model_width);
        if (w < 1) w = 1;
        if (w > MAX_W) w = MAX_W;
        return w;
    endfunction

    function automatic int used_height();
        int h;
        h = int'(model_height);
        if (h < 8) h = 8;
        if (h > MAX_H) h = MAX_H;
        return h - (h % 8);
    endfunction

    function automatic void plot_pixel(input int x, input int y);
        int w;
        int h;
        int idx;
        w = used_width();
        h = used_height();
        if (x < 0 || y < 0 || x >= w || y >= h) return;
        idx = (y / 8) * w + x;
        if (idx >= STORE_DEPTH) return;
        pixel_pages[idx][y % 8] = model_colour;
    endfunction

    function automatic void trace_line(input int x0, input int y0, input int x1, input int y1);
        int dx;
        int dy;
        int step_x;
        int step_y;
        int slope_err;
        int lo;
        int hi;
        int i;
        bit x_major;
        if (x0 == x1 || y0 == y1) begin
            lo = (x0 == x1) ? y0 : x0;
            hi = (x0 == x1) ? y1 : x1;
            if (lo > hi) begin
                i = lo;
                lo = hi;
                hi = i;
            end
            for (i = lo; i <= hi; i++) begin
                if (x0 == x1) plot_pixel(x0, i);
                else plot_pixel(i, y0);
            end
            return;
        end
        dx = (x1 > x0) ? x1 - x0 : x0 - x1;
        dy = (y1 > y0) ? y1 - y0 : y0 - y1;
        step_x = (x1 > x0) ? 1 : -1;
        step_y = (y1 > y0) ? 1 : -1;
        x_major = (dx >= dy);
        slope_err = x_major ? 2 * dy - dx : 2 * dx - dy;
        forever begin
            plot_pixel(x0, y0);
            if (x0 == x1 && y0 == y1) break;
            if (x_major) begin
                if (slope_err > 0) begin
                    y0 += step_y;
                    slope_err -= 2 * dx;
                end
                x0 += step_x;
                slope_err += 2 * dy;
            end else begin
                if (slope_err > 0) begin
                    x0 += step_x;
                    slope_err -= 2 * dy;
                end
                y0 += step_y;
                slope_err += 2 * dx;
            end
        end
    endfunction

    function automatic read_reply_t predict_reply(input pix_req_t r);
        read_reply_t rep;
        int span;
        rep.data = blpf_pkg::BLANK_BYTE;
        rep.err = 1'b0;
        case (r.op)
            blpf_pkg::OP_DRAW: begin
                if (model_enable)
                    trace_line(int'($signed(r.sx)), int'($signed(r.sy)),
                               int'($signed(r.ex)), int'($signed(r.ey)));
            end
            blpf_pkg::OP_READ: begin
                span = used_width() * used_height() / 8;
                if (int'(r.addr) >= span || int'(r.addr) >= STORE_DEPTH) rep.err = 1'b1;
                else rep.data = pixel_pages[r.addr];
            end
            blpf_pkg::OP_CLEAR: begin
                foreach (pixel_pages[i]) pixel_pages[i] = blpf_pkg::BLANK_BYTE;
            end
            default: ;
        endcase
        return rep;
    endfunction

    function automatic int idle_gap();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 10) return 0;
        if (pick < 17) return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    function automatic logic signed [blpf_pkg::COORD_W-1:0] near_coord(input int extent);
        return blpf_pkg::COORD_W'(int'($urandom_range(0, extent + 24)) - 12);
    endfunction

    function automatic pix_req_t random_request();
        pix_req_t r;
        int pick;
        int shape;
        int w;
        int h;
        int span;
        w = used_width();
        h = used_height();
        span = w * h / 8;
        r.sx = blpf_pkg::COORD_W'($urandom);
        r.sy = blpf_pkg::COORD_W'($urandom);
        r.ex = blpf_pkg::COORD_W'($urandom);
        r.ey = blpf_pkg::COORD_W'($urandom);
        r.addr = blpf_pkg::ADDR_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            r.op = blpf_pkg::OP_DRAW;
            shape = $urandom_range(0, 99);
            if (shape >= 3) begin
                r.sx = near_coord(w);
                r.sy = near_coord(h);
                r.ex = near_coord(w);
                r.ey = near_coord(h);
                if (shape < 18) r.ey = r.sy;
                else if (shape < 33) r.ex = r.sx;
                else if (shape < 38) begin
                    r.ex = r.sx;
                    r.ey = r.sy;
                end
            end
        end else if (pick < 90) begin
            r.op = blpf_pkg::OP_READ;
            if ($urandom_range(0, 3) != 0)
                r.addr = blpf_pkg::ADDR_W'($urandom_range(0, span - 1));
        end else if (pick < 94) begin
            r.op = blpf_pkg::OP_CLEAR;
        end else begin
            r.op = OP_SPARE;
        end
        return r;
    endfunction

    // Presents one item and returns at the clock edge on which its transfer happens.
    task automatic issue(input pix_req_t r, input bit use_given, input read_reply_t given);
        int gap;
        read_reply_t rep;
        gap = steady_source ? 0 : idle_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_operation    <= r.op;
        s_start_x      <= r.sx;
        s_start_y      <= r.sy;
        s_end_x        <= r.ex;
        s_end_y        <= r.ey;
        s_read_address <= r.addr;
        do @(posedge aclk); while (s_ready !== 1'b1);
        rep = predict_reply(r);
        replies_due.push_back(use_given ? given : rep);
    endtask

    task automatic wait_for_idle();
        s_valid <= 1'b0;
        while (replies_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [blpf_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [7:0] val);
        cfg_write_enable <= 1'b1;
        cfg_index        <= idx;
        cfg_data         <= val;
        @(posedge aclk);
        case (idx)
            blpf_pkg::CFG_DISPLAY_WIDTH:  model_width  = val;
            blpf_pkg::CFG_DISPLAY_HEIGHT: model_height = val[6:0];
            blpf_pkg::CFG_STROKE_ENABLE:  model_enable = val[0];
            blpf_pkg::CFG_STROKE_COLOUR:  model_colour = val[0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [7:0] w, input logic [7:0] h,
                             input logic en, input logic col);
        wait_for_idle();
        write_reg(blpf_pkg::CFG_DISPLAY_WIDTH, w);
        write_reg(blpf_pkg::CFG_DISPLAY_HEIGHT, {1'b0, h[6:0]});
        write_reg(blpf_pkg::CFG_STROKE_ENABLE, {7'd0, en});
        write_reg(blpf_pkg::CFG_STROKE_COLOUR, {7'd0, col});
        cfg_write_enable <= 1'b0;
    endtask

    always @(posedge aclk) begin : result_check
        read_reply_t due;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            results_seen++;
            if (replies_due.size() == 0) begin
                $display("%0t: unexpected result, read_data %02h address_error %0b",
                         $time, m_read_data, m_address_error);
                mismatches++;
            end else begin
                due = replies_due.pop_front();
                if (m_read_data !== due.data) begin
                    $display("%0t: read_data expected %02h, got %02h",
                             $time, due.data, m_read_data);
                    mismatches++;
                end
                if (m_address_error !== due.err) begin
                    $display("%0t: address_error expected %0b, got %0b",
                             $time, due.err, m_address_error);
                    mismatches++;
                end
            end
        end
    end

    // The receiver holds off twice for a long stretch so that the block backs up.
    initial begin : result_sink
        int run;
        int gap;
        int holds;
        holds = 0;
        @(posedge aclk);
        forever begin
            if ((holds == 0 && results_seen >= 200) || (holds == 1 && results_seen >= 800)) begin
                holds++;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= 1'b1;
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 12);
            repeat (run) @(posedge aclk);
            gap = idle_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("bresenham_line_to_page_framebuffer_core_test: FAIL");
            $finish;
        end
    end

    initial begin
        foreach (pixel_pages[i]) pixel_pages[i] = blpf_pkg::BLANK_BYTE;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++)
            issue(DIRECTED[i].req, DIRECTED[i].typed, DIRECTED[i].reply);

        for (int p = 0; p < PHASES; p++) begin
            if (p < 8)
                configure(PHASE_WIDTH[p], PHASE_HEIGHT[p], PHASE_ENABLE[p], PHASE_COLOUR[p]);
            else
                configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 127)),
                          $urandom_range(0, 3) != 0, $urandom_range(0, 2) != 0);
            steady_source = (p % 3 == 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 99) == 0) wait_for_idle();
                issue(random_request(), 1'b0, '0);
            end
        end

        wait_for_idle();
        repeat (SETTLE) @(posedge aclk);
        if (mismatches == 0)
            $display("bresenham_line_to_page_framebuffer_core_test: PASS");
        else
            $display("bresenham_line_to_page_framebuffer_core_test: FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/blpf_pkg.sv
hdl/blpf_datapath.sv
hdl/blpf_ctrl.sv
hdl/bresenham_line_to_page_framebuffer_core.sv
tb/bresenham_line_to_page_framebuffer_core_test.sv
